// ===== src/sldf_pkg.sv =====
`default_nettype none

package sldf_pkg;

    localparam logic [7:0]  SYNC_FIRST        = 8'h94;
    localparam logic [7:0]  SYNC_SECOND       = 8'hC3;
    localparam int unsigned HEADER_BYTES      = 4;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd508;

    // Header detector result for the byte being hunted
    typedef struct packed {
        logic        ok;
        logic [15:0] len;
    } t_hdr;

endpackage

`default_nettype wire

// ===== src/sldf_hunt.sv =====
`default_nettype none

module sldf_hunt (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,          // hunting byte accepted this cycle
    input  wire logic [7:0]   i_byte,
    input  wire logic [15:0]  i_max_payload,
    output sldf_pkg::t_hdr    o_hdr
);
    import sldf_pkg::*;

    localparam int unsigned FILL_W = $clog2(HEADER_BYTES);

    logic [7:0]        r_win [HEADER_BYTES-1];
    logic [FILL_W-1:0] r_fill;
    logic [15:0]       w_len;
    logic              w_full;

    // The incoming byte completes the window when three are already held
    assign w_full = (r_fill == FILL_W'(HEADER_BYTES - 1));
    assign w_len  = {r_win[HEADER_BYTES-2], i_byte};

    assign o_hdr.len = w_len;
    assign o_hdr.ok  = w_full && (r_win[0] == SYNC_FIRST) && (r_win[1] == SYNC_SECOND)
                       && (w_len != 16'd0) && (w_len <= i_max_payload);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_en) begin
            if (!w_full) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (o_hdr.ok) begin
                r_fill <= '0;
            end
        end
    end

    // Slide on a rejected header; window bytes beyond the fill count are never read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!w_full) begin
                r_win[r_fill] <= i_byte;
            end else begin
                for (int i = 0; i < HEADER_BYTES - 2; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[HEADER_BYTES-2] <= i_byte;
            end
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HEADER_BYTES - 1))
        else $error("hunt window fill out of range");

    a_ok_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_hdr.ok) |=> (r_fill == '0))
        else $error("window not cleared after header match");

endmodule

`default_nettype wire

// ===== src/sync_length_frame_deframer_core.sv =====
`default_nettype none
// A payload byte appears on the master side in the cycle after its transaction.
// One byte per cycle while the master side takes each result; the output register frees as soon as it is taken,
// so a new byte enters in the cycle its predecessor leaves.
// Header bytes give no result. Reset (synchronous, active low) returns to hunting
// with an empty window and sets max_payload to 508.
module sync_length_frame_deframer_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [15:0]  i_cfg_data,     // max_payload
    // received bytes
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,      // [7:0] rx_byte
    // payload bytes
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [23:0]       o_m_tdata,      // [7:0] payload_byte, [23:8] frame_length
    output logic              o_m_tlast,      // last_of_frame
    output logic              o_m_tuser       // first_of_frame
);
    import sldf_pkg::*;

    logic [15:0] r_max_payload;
    logic [15:0] r_remain, n_remain;
    logic [15:0] r_len, n_len;
    logic        r_out_valid, n_out_valid;
    logic [23:0] r_out_data;
    logic        r_out_last;
    logic        r_out_first;
    logic        w_accept;
    logic        w_in_payload;
    t_hdr        w_hdr;

    assign o_cfg_ready  = 1'b1;
    assign o_s_tready   = !r_out_valid || i_m_tready;
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_in_payload = (r_remain != 16'd0);

    sldf_hunt u_hunt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_accept && !w_in_payload),
        .i_byte        (i_s_tdata),
        .i_max_payload (r_max_payload),
        .o_hdr         (w_hdr)
    );

    always_comb begin
        n_remain    = r_remain;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_m_tready;
        if (w_accept) begin
            if (w_in_payload) begin
                n_remain    = r_remain - 16'd1;
                n_out_valid = 1'b1;
            end else if (w_hdr.ok) begin
                n_remain = w_hdr.len;
                n_len    = w_hdr.len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
            r_remain      <= '0;
            r_len         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_payload <= i_cfg_data;
            end
            r_remain    <= n_remain;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // Load the result register only on a payload transaction
    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_payload) begin
            r_out_data  <= {r_len, i_s_tdata};
            r_out_first <= (r_remain == r_len);
            r_out_last  <= (r_remain == 16'd1);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_first;

    a_remain_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_remain != 16'd0) |-> (r_len != 16'd0 && r_remain <= r_len))
        else $error("remaining count exceeds frame length");

    a_out_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[23:8] != 16'd0))
        else $error("payload byte with zero frame length");

    a_hdr_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_in_payload && w_hdr.ok) |=> (r_remain == $past(w_hdr.len)))
        else $error("header match did not load the byte count");

    a_no_out_when_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_in_payload && !(r_out_valid && !i_m_tready)) |=> !o_m_tvalid)
        else $error("result produced for a hunting byte");

endmodule

`default_nettype wire

// ===== test/tb_sync_length_frame_deframer_core.sv =====
`timescale 1ns / 1ps

module tb_sync_length_frame_deframer_core;
    import sldf_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 116;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        first_of_frame;
        logic        last_of_frame;
        logic [15:0] frame_length;
    } t_payload_beat;

    // Shadow of the deframer: hunt window, payload counter and limit register,
    // plus the queue of payload beats still owed by the block.
    class deframer_scoreboard;
        logic [7:0]    hdr_window [HEADER_BYTES];
        int unsigned   hdr_fill;
        bit            in_payload;
        logic [15:0]   bytes_left;
        logic [15:0]   frame_len;
        logic [15:0]   max_payload;
        t_payload_beat beats_due [$];
        int            mismatches;
        int            beats_checked;
        int            frames_checked;

        function new();
            foreach (hdr_window[i]) hdr_window[i] = '0;
            hdr_fill       = 0;
            in_payload     = 1'b0;
            bytes_left     = '0;
            frame_len      = '0;
            max_payload    = MAX_PAYLOAD_RESET;
            mismatches     = 0;
            beats_checked  = 0;
            frames_checked = 0;
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        function void note_byte(logic [7:0] rx);
            t_payload_beat beat;
            logic [15:0]   hdr_len;
            if (in_payload && bytes_left == 16'd0) in_payload = 1'b0;
            if (in_payload) begin
                beat.payload_byte   = rx;
                beat.first_of_frame = (bytes_left == frame_len);
                beat.last_of_frame  = (bytes_left == 16'd1);
                beat.frame_length   = frame_len;
                beats_due.push_back(beat);
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) in_payload = 1'b0;
                return;
            end
            if (hdr_fill >= HEADER_BYTES) hdr_fill = HEADER_BYTES - 1;
            hdr_window[hdr_fill] = rx;
            hdr_fill++;
            if (hdr_fill == HEADER_BYTES) begin
                hdr_len = {hdr_window[2], hdr_window[3]};
                if (hdr_window[0] == SYNC_FIRST && hdr_window[1] == SYNC_SECOND &&
                    hdr_len != 16'd0 && hdr_len <= max_payload) begin
                    foreach (hdr_window[i]) hdr_window[i] = '0;
                    hdr_fill   = 0;
                    in_payload = 1'b1;
                    bytes_left = hdr_len;
                    frame_len  = hdr_len;
                end else begin
                    // slide: drop the oldest byte
                    for (int i = 0; i < HEADER_BYTES - 1; i++) hdr_window[i] = hdr_window[i + 1];
                    hdr_window[HEADER_BYTES - 1] = '0;
                    hdr_fill = HEADER_BYTES - 1;
                end
            end
        endfunction

        function void check_result(logic [23:0] tdata, logic tlast, logic tuser);
            t_payload_beat want;
            t_payload_beat got;
            got.payload_byte   = tdata[7:0];
            got.frame_length   = tdata[23:8];
            got.first_of_frame = tuser;
            got.last_of_frame  = tlast;
            beats_checked++;
            if (got.last_of_frame) frames_checked++;
            if (beats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected payload byte %02h len %0d first %0b last %0b",
                             $time, got.payload_byte, got.frame_length,
                             got.first_of_frame, got.last_of_frame);
                return;
            end
            want = beats_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"[%0t] payload mismatch: expected byte %02h len %0d first %0b ",
                              "last %0b, got byte %02h len %0d first %0b last %0b"},
                             $time, want.payload_byte, want.frame_length,
                             want.first_of_frame, want.last_of_frame,
                             got.payload_byte, got.frame_length,
                             got.first_of_frame, got.last_of_frame);
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;      // [7:0] payload_byte, [23:8] frame_length
    logic        o_m_tlast;      // last_of_frame
    logic        o_m_tuser;      // first_of_frame

    deframer_scoreboard sb;
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int bytes_sent       = 0;
    int settings_written = 0;
    int cycles           = 0;
    logic [15:0] phase_limits [5] = '{16'd5, 16'd96, 16'd16, 16'd300, 16'd1};

    sync_length_frame_deframer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
    end

    // Payload sink: random stall before each transaction while rx_idle is set
    initial begin : payload_sink
        int stall;
        forever begin
            stall = rx_idle ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    function automatic logic [7:0] random_rx_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return SYNC_FIRST;
        if (pick == 1) return SYNC_SECOND;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(value);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [15:0] len);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_frame(input logic [15:0] len);
        send_header(len);
        repeat (len) send_byte(random_rx_byte());
    endtask

    // Hold off the sender until every owed payload byte has left the block
    task automatic wait_for_payload_drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_payload(input logic [15:0] value);
        wait_for_payload_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.max_payload = value;
        settings_written++;
    endtask

    task automatic run_phase(input logic [15:0] limit, input bit pressure);
        int          start;
        int          r;
        int          len_cap;
        logic [15:0] bad_len;
        bit          only_frames;
        // with the widest limit, broken headers could open huge frames
        only_frames = (limit == 16'hFFFF);
        start = bytes_sent;
        while (bytes_sent - start < PHASE_ITEMS) begin
            if (pressure && bytes_sent - start >= PHASE_ITEMS / 2) begin
                wait_for_payload_drain();
                pressure = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (only_frames || r < 70) begin
                r = $urandom_range(0, 99);
                len_cap = (r < 80) ? 12 : (r < 95) ? 64 : 200;
                if (len_cap > limit) len_cap = limit;
                send_frame(16'($urandom_range(1, len_cap)));
            end else if (r < 80) begin
                bad_len = $urandom_range(0, 1) ? 16'd0 : limit + 16'd1;
                send_header(bad_len);
            end else if (r < 90) begin
                repeat ($urandom_range(1, 6)) send_byte(random_rx_byte());
            end else begin
                send_byte(SYNC_FIRST);
                if ($urandom_range(0, 1)) send_byte(SYNC_SECOND);
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte frame, zero length, one over the reset limit
        send_header(16'd1);
        send_byte(8'hFF);
        send_header(16'd0);
        send_header(MAX_PAYLOAD_RESET + 16'd1);
        // sync bytes carried as payload, then a length just past the limit
        write_max_payload(16'd3);
        send_header(16'd3);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h00);
        send_header(16'd4);
        // zero limit: nothing is ever accepted
        write_max_payload(16'd0);
        send_header(16'd1);
        send_byte(8'h00);
        // lower the limit mid-frame; the open frame keeps its length
        write_max_payload(16'hFFFF);
        send_header(16'd2);
        send_byte(8'h00);
        write_max_payload(16'd1);
        send_byte(8'hFF);
        send_header(16'd2);

        write_max_payload(MAX_PAYLOAD_RESET);
        run_phase(MAX_PAYLOAD_RESET, 1'b1);
        foreach (phase_limits[i]) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            write_max_payload(phase_limits[i]);
            run_phase(phase_limits[i], 1'b0);
        end
        // realign the window with a one-byte frame before opening the limit wide
        while (sb.in_payload) send_byte(random_rx_byte());
        send_frame(16'd1);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_max_payload(16'hFFFF);
        run_phase(16'hFFFF, 1'b0);

        wait_for_payload_drain();
        repeat (10) @(posedge i_clk);

        $display("Streamed %0d serial bytes under %0d max_payload writes.",
                 bytes_sent, settings_written);
        $display("Checked %0d payload bytes in %0d frames, %0d mismatches.",
                 sb.beats_checked, sb.frames_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
